// ===== rtl/nmea_sf_pkg.sv =====
package nmea_sf_pkg;

   // sentence length limit, the byte count saturates here
   localparam logic [7:0] MAX_SENTENCE_LEN = 8'd255;

   // framing characters
   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_LOW   = 8'h20;  // ' '
   localparam logic [7:0] CH_HIGH  = 8'h7E;  // '~'

   // digit code meaning "not a hex digit"
   localparam logic [4:0] HEX_NONE = 5'd16;

   typedef enum logic [1:0] {
      ST_REJECT   = 2'd0,
      ST_START    = 2'd1,
      ST_STORED   = 2'd2,
      ST_COMPLETE = 2'd3
   } status_type;

   // digit value 0..15, or HEX_NONE
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] d;
      d = HEX_NONE;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = 5'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = 5'(b - 8'h41 + 8'd10);
      end
      return d;
   endfunction

endpackage

// ===== rtl/nmea_sentence_framer_checksum.sv =====
// channel | ports              | payload (lowest bit first)
// --------+--------------------+-------------------------------------------------
// input   | req_tvalid/tready  | tdata: rx_byte[7:0]
// result  | rsp_tvalid/tready  | tdata: stored_byte[7:0], stored_position[7:0],
//         |                    |        checksum_ok, zero pad; tuser: status[1:0]
//
// one byte per cycle while the result is not stalled; a byte is held in the
// input register and its result is then loaded into the result register
// the sentence state is updated in the same cycle the result register is loaded
// reset is synchronous, active high, and empties both registers and the state
// a stalled result holds the input register; the input side keeps taking
// transactions as long as the input register can move on
module nmea_sentence_framer_checksum
   import nmea_sf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // stored_byte[7:0], stored_position[15:8],
                                    // checksum_ok[16], zeros[23:17]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [7:0] out_pos_ff, out_pos_in;
   logic       out_ok_ff, out_ok_in;

   // sentence state
   logic [7:0] count_ff, count_in;
   logic [7:0] last_ff, last_in;
   logic [7:0] xor_ff, xor_in;
   logic       star_ff, star_in;
   logic       hex_act_ff, hex_act_in;
   logic [7:0] hex_val_ff, hex_val_in;
   logic       hex_ovf_ff, hex_ovf_in;

   logic       advance;
   logic       req_take;
   logic       is_print;
   logic [4:0] digit;

   // the input register moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {7'd0, out_ok_ff, out_pos_ff, out_byte_ff};

   assign is_print = (in_byte_ff >= CH_LOW) && (in_byte_ff <= CH_HIGH);
   assign digit    = hex_digit(in_byte_ff);

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_comb begin
      count_in      = count_ff;
      last_in       = last_ff;
      xor_in        = xor_ff;
      star_in       = star_ff;
      hex_act_in    = hex_act_ff;
      hex_val_in    = hex_val_ff;
      hex_ovf_in    = hex_ovf_ff;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_pos_in    = out_pos_ff;
      out_ok_in     = out_ok_ff;
      if (advance) begin
         out_status_in = ST_REJECT;
         out_byte_in   = 8'd0;
         out_pos_in    = 8'd0;
         out_ok_in     = 1'b0;
         if (in_byte_ff == CH_START) begin
            // '$' opens a fresh sentence at position 0
            count_in      = 8'd1;
            last_in       = in_byte_ff;
            xor_in        = 8'd0;
            star_in       = 1'b0;
            hex_act_in    = 1'b0;
            hex_val_in    = 8'd0;
            hex_ovf_in    = 1'b0;
            out_status_in = ST_START;
            out_byte_in   = in_byte_ff;
         end else if ((is_print && count_ff != 8'd0) || in_byte_ff == CH_CR) begin
            // stored byte; count saturates at the length limit
            if (count_ff < MAX_SENTENCE_LEN) begin
               count_in = count_ff + 8'd1;
            end
            last_in = in_byte_ff;
            if (!star_ff) begin
               if (in_byte_ff == CH_STAR) begin
                  star_in    = 1'b1;
                  hex_act_in = 1'b1;
                  hex_val_in = 8'd0;
                  hex_ovf_in = 1'b0;
               end else if (count_ff != 8'd0) begin
                  xor_in = xor_ff ^ in_byte_ff;
               end
            end else if (hex_act_ff) begin
               if (digit != HEX_NONE) begin
                  // a value already above one digit shifts bits out
                  if (hex_val_ff[7:4] != 4'd0) begin
                     hex_ovf_in = 1'b1;
                  end
                  hex_val_in = {hex_val_ff[3:0], digit[3:0]};
               end else begin
                  hex_act_in = 1'b0;
               end
            end
            out_status_in = ST_STORED;
            out_byte_in   = in_byte_ff;
            out_pos_in    = count_ff;
         end else if (in_byte_ff == CH_LF && count_ff > 8'd1 && last_ff == CH_CR) begin
            // CR LF closes the sentence and reports the check
            out_ok_in     = star_ff && !hex_ovf_ff && (count_ff < MAX_SENTENCE_LEN) &&
                            (hex_val_ff == xor_ff);
            out_status_in = ST_COMPLETE;
            count_in      = 8'd0;
            last_in       = 8'd0;
            xor_in        = 8'd0;
            star_in       = 1'b0;
            hex_act_in    = 1'b0;
            hex_val_in    = 8'd0;
            hex_ovf_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= 8'd0;
         last_ff      <= 8'd0;
         xor_ff       <= 8'd0;
         star_ff      <= 1'b0;
         hex_act_ff   <= 1'b0;
         hex_val_ff   <= 8'd0;
         hex_ovf_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         xor_ff       <= xor_in;
         star_ff      <= star_in;
         hex_act_ff   <= hex_act_in;
         hex_val_ff   <= hex_val_in;
         hex_ovf_ff   <= hex_ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_pos_ff    <= out_pos_in;
      out_ok_ff     <= out_ok_in;
   end

endmodule
